// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants of the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

   // number of register stages in the datapath
   localparam int NUM_STAGES = 7;

   // width of the secondary channel quotient before the final divide by fifteen
   localparam int QUOT_W = 12;

   // floor(y / 15) for y below 2**QUOT_W: multiply by 4369 / 2**16, then fix by one
   localparam int DIV15_DIVISOR = 15;
   localparam int DIV15_RECIP_W = 13;
   localparam logic [DIV15_RECIP_W-1:0] DIV15_RECIP = 13'd4369;
   localparam int DIV15_SHIFT = 16;

   // hue sector codes, one per 60 degrees
   typedef enum logic [2:0] {
      SECT_0 = 3'd0,
      SECT_1 = 3'd1,
      SECT_2 = 3'd2,
      SECT_3 = 3'd3,
      SECT_4 = 3'd4,
      SECT_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic signed [15:0] hue;
      logic signed [15:0] saturation;
      logic signed [15:0] brightness;
      logic [7:0]         alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_out;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== design/hsv2rgb_req_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_req_if
// valid/ready channel carrying one hsv pixel with alpha
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_req_if
   import hsv2rgb_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/hsv2rgb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_rsp_if
// valid/ready channel carrying one rgba pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_rsp_if
   import hsv2rgb_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// splits a reduced hue into its sector and the distance from the sector
// pair's center
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_sector
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 6
) (
   input  wire logic [$clog2(360 << HUE_FRAC_BITS)-1:0]      hue_mod,
   output sector_type                                        sector,
   output logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0]      center_gap
);

   localparam int SECTOR = 60 << HUE_FRAC_BITS;
   localparam int FULL   = 6 * SECTOR;
   localparam int RW     = $clog2(FULL);
   localparam int DW     = $clog2(SECTOR + 1);

   logic [1:0]    pair;
   logic [RW-1:0] t;
   logic          upper;

   always_comb begin
      priority if (hue_mod >= RW'(4 * SECTOR)) begin
         pair = 2'd2;
         t    = hue_mod - RW'(4 * SECTOR);
      end else if (hue_mod >= RW'(2 * SECTOR)) begin
         pair = 2'd1;
         t    = hue_mod - RW'(2 * SECTOR);
      end else begin
         pair = 2'd0;
         t    = hue_mod;
      end
      upper = (t >= RW'(SECTOR));
      // |t - sector|, at most one sector
      if (upper) begin
         center_gap = DW'(t - RW'(SECTOR));
      end else begin
         center_gap = DW'(RW'(SECTOR) - t);
      end
      sector = sector_type'({pair, upper});
   end

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_converter_unit.sv =====
// the pipeline has 7 stages; a transaction accepted into stage 1 is offered on rsp_stream from stage 7
// throughput: one pixel per cycle while rsp_stream is ready, a new transaction may then enter every clock
// a stalled result holds in the output stage while earlier stages keep filling bubbles
// reset clears only the stage valid bits; the datapath registers are not reset
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// seven-stage pipeline turning hsv plus alpha into 8-bit rgba
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SV_FRAC_BITS  = 14
) (
   input  wire logic     clock,
   input  wire logic     reset,
   hsv2rgb_req_if.sink   req_stream,
   hsv2rgb_rsp_if.source rsp_stream
);

   // unit values and widths
   localparam int ONE      = 1 << SV_FRAC_BITS;
   localparam int SVW      = SV_FRAC_BITS + 1;            // clamped s and v, 0..ONE
   localparam int SECTOR   = 60 << HUE_FRAC_BITS;         // one sector in hue units
   localparam int FULL     = 6 * SECTOR;                  // full turn in hue units
   localparam int DW       = $clog2(SECTOR + 1);
   localparam int RW       = $clog2(FULL);
   // offset that lifts any 16-bit hue to a non-negative multiple-of-turn shift
   localparam int HUE_OFS  = FULL * ((32768 + FULL - 1) / FULL);
   localparam int HPW      = $clog2(HUE_OFS + 32768);
   localparam int HUE_RECIP = (1 << HPW) / FULL;          // low by at most one turn
   localparam int EW       = SV_FRAC_BITS + DW;
   localparam int FW       = SVW + EW;
   localparam int GW       = FW + 8;
   // ONE*ONE*SECTOR = 15 * 2**XSH
   localparam int XSH      = 2 * SV_FRAC_BITS + HUE_FRAC_BITS + 2;
   localparam int QMAX     = DIV15_DIVISOR * 256 - 1;

   // ---------------------------------------------------------------------
   // flow control: a stage takes new data when it is empty or its own
   // content moves on in the same cycle
   // ---------------------------------------------------------------------
   logic [NUM_STAGES:1]   vld_ff;
   logic [NUM_STAGES+1:1] adv;

   always_comb begin
      adv[NUM_STAGES+1] = rsp_stream.ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stream.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= req_stream.valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: clamp s and v, lift the hue, estimate full turns
   // ---------------------------------------------------------------------
   logic [SVW-1:0]     s1_sat_in, s1_val_in, s1_sat_ff, s1_val_ff;
   logic [HPW-1:0]     s1_hp_in, s1_hp_ff, s1_turns_in, s1_turns_ff;
   logic [2*HPW-1:0]   turn_prod;
   logic [7:0]         s1_alpha_ff;
   logic signed [15:0] in_hue, in_sat, in_val;

   assign in_hue = req_stream.payload.hue;
   assign in_sat = req_stream.payload.saturation;
   assign in_val = req_stream.payload.brightness;

   always_comb begin
      priority if (in_sat[15]) begin
         s1_sat_in = '0;
      end else if (in_sat[14:0] > 15'(ONE)) begin
         s1_sat_in = SVW'(ONE);
      end else begin
         s1_sat_in = in_sat[SVW-1:0];
      end
      priority if (in_val[15]) begin
         s1_val_in = '0;
      end else if (in_val[14:0] > 15'(ONE)) begin
         s1_val_in = SVW'(ONE);
      end else begin
         s1_val_in = in_val[SVW-1:0];
      end
   end

   // sign-extended hue plus offset is always in 0 .. 2**HPW-1
   assign s1_hp_in    = {{(HPW-16){in_hue[15]}}, in_hue} + HPW'(HUE_OFS);
   assign turn_prod   = s1_hp_in * HPW'(HUE_RECIP);
   assign s1_turns_in = turn_prod[2*HPW-1:HPW];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_sat_ff   <= s1_sat_in;
         s1_val_ff   <= s1_val_in;
         s1_hp_ff    <= s1_hp_in;
         s1_turns_ff <= s1_turns_in;
         s1_alpha_ff <= req_stream.payload.alpha_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: finish hue mod 360, byte for the chroma channel, v*(1-s)
   // ---------------------------------------------------------------------
   logic [2*HPW-1:0] turn_sub;
   logic [HPW-1:0]   hue_rem;
   logic [RW-1:0]    s2_hue_in, s2_hue_ff;
   logic [SVW+7:0]   val_x255;
   logic [7:0]       s2_byte_c_in, s2_byte_c_ff;
   logic [2*SVW-1:0] s2_low_in, s2_low_ff;
   logic [SVW-1:0]   s2_sat_ff, s2_val_ff;
   logic [7:0]       s2_alpha_ff;

   assign turn_sub = s1_turns_ff * HPW'(FULL);
   assign hue_rem  = s1_hp_ff - turn_sub[HPW-1:0];

   always_comb begin
      // the estimate is at most one turn short
      if (hue_rem >= HPW'(FULL)) begin
         s2_hue_in = RW'(hue_rem - HPW'(FULL));
      end else begin
         s2_hue_in = RW'(hue_rem);
      end
   end

   // channel holding c + m is v * 255 / ONE
   assign val_x255     = {s1_val_ff, 8'd0} - (SVW+8)'(s1_val_ff);
   assign s2_byte_c_in = val_x255[SV_FRAC_BITS+7:SV_FRAC_BITS];
   assign s2_low_in    = s1_val_ff * (SVW'(ONE) - s1_sat_ff);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_hue_ff    <= s2_hue_in;
         s2_byte_c_ff <= s2_byte_c_in;
         s2_low_ff    <= s2_low_in;
         s2_sat_ff    <= s1_sat_ff;
         s2_val_ff    <= s1_val_ff;
         s2_alpha_ff  <= s1_alpha_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: sector and distance from center, byte for the zero channel
   // ---------------------------------------------------------------------
   sector_type       s3_sector_in, s3_sector_ff;
   logic [DW-1:0]    s3_dist_in, s3_dist_ff;
   logic [2*SVW+7:0] low_x255;
   logic [7:0]       s3_byte_0_ff, s3_byte_c_ff;
   logic [SVW-1:0]   s3_sat_ff, s3_val_ff;
   logic [7:0]       s3_alpha_ff;

   hsv2rgb_sector #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_sector (
      .hue_mod    (s2_hue_ff),
      .sector     (s3_sector_in),
      .center_gap (s3_dist_in)
   );

   // channel holding only m is v*(ONE-s) * 255 / ONE**2
   assign low_x255 = {s2_low_ff, 8'd0} - (2*SVW+8)'(s2_low_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_sector_ff <= s3_sector_in;
         s3_dist_ff   <= s3_dist_in;
         s3_byte_0_ff <= low_x255[2*SV_FRAC_BITS+7:2*SV_FRAC_BITS];
         s3_byte_c_ff <= s2_byte_c_ff;
         s3_sat_ff    <= s2_sat_ff;
         s3_val_ff    <= s2_val_ff;
         s3_alpha_ff  <= s2_alpha_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 4: e = ONE*SECTOR - s*dist, so x + m = v*e / (ONE*SECTOR)
   // ---------------------------------------------------------------------
   logic [SVW+DW-1:0] sat_dist, e_full;
   logic [EW-1:0]     s4_e_ff;
   sector_type        s4_sector_ff;
   logic [7:0]        s4_byte_0_ff, s4_byte_c_ff, s4_alpha_ff;
   logic [SVW-1:0]    s4_val_ff;

   assign sat_dist = s3_sat_ff * DW'(s3_dist_ff);
   assign e_full   = (SVW+DW)'(ONE * SECTOR) - sat_dist;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_e_ff      <= e_full[EW-1:0];
         s4_val_ff    <= s3_val_ff;
         s4_sector_ff <= s3_sector_ff;
         s4_byte_0_ff <= s3_byte_0_ff;
         s4_byte_c_ff <= s3_byte_c_ff;
         s4_alpha_ff  <= s3_alpha_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 5: f = v * e
   // ---------------------------------------------------------------------
   logic [FW-1:0] s5_f_in, s5_f_ff;
   sector_type    s5_sector_ff;
   logic [7:0]    s5_byte_0_ff, s5_byte_c_ff, s5_alpha_ff;

   assign s5_f_in = s4_val_ff * s4_e_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_f_ff      <= s5_f_in;
         s5_sector_ff <= s4_sector_ff;
         s5_byte_0_ff <= s4_byte_0_ff;
         s5_byte_c_ff <= s4_byte_c_ff;
         s5_alpha_ff  <= s4_alpha_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 6: y = floor(255*f / 2**XSH); the byte is then floor(y / 15)
   // ---------------------------------------------------------------------
   logic [GW-1:0]     f_x255;
   logic [QUOT_W-1:0] s6_y_ff;
   sector_type        s6_sector_ff;
   logic [7:0]        s6_byte_0_ff, s6_byte_c_ff, s6_alpha_ff;

   assign f_x255 = {s5_f_ff, 8'd0} - GW'(s5_f_ff);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_y_ff      <= f_x255[XSH+QUOT_W-1:XSH];
         s6_sector_ff <= s5_sector_ff;
         s6_byte_0_ff <= s5_byte_0_ff;
         s6_byte_c_ff <= s5_byte_c_ff;
         s6_alpha_ff  <= s5_alpha_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 7: divide by fifteen, place c, x and zero by sector
   // ---------------------------------------------------------------------
   logic [QUOT_W+DIV15_RECIP_W-1:0] div_prod;
   logic [7:0]                      quot_est, byte_x;
   logic [QUOT_W-1:0]               quot_x15, div_rem;
   logic [7:0]                      red_in, green_in, blue_in;
   logic [7:0]                      red_ff, green_ff, blue_ff, alpha_ff;

   assign div_prod = s6_y_ff * DIV15_RECIP;
   assign quot_est = div_prod[DIV15_SHIFT+7:DIV15_SHIFT];
   assign quot_x15 = {quot_est, 4'd0} - QUOT_W'(quot_est);
   assign div_rem  = s6_y_ff - quot_x15;
   // estimate is low by at most one
   assign byte_x   = (div_rem >= QUOT_W'(DIV15_DIVISOR)) ? quot_est + 8'd1 : quot_est;

   always_comb begin
      unique case (s6_sector_ff)
         SECT_0: begin
            red_in = s6_byte_c_ff; green_in = byte_x;       blue_in = s6_byte_0_ff;
         end
         SECT_1: begin
            red_in = byte_x;       green_in = s6_byte_c_ff; blue_in = s6_byte_0_ff;
         end
         SECT_2: begin
            red_in = s6_byte_0_ff; green_in = s6_byte_c_ff; blue_in = byte_x;
         end
         SECT_3: begin
            red_in = s6_byte_0_ff; green_in = byte_x;       blue_in = s6_byte_c_ff;
         end
         SECT_4: begin
            red_in = byte_x;       green_in = s6_byte_0_ff; blue_in = s6_byte_c_ff;
         end
         default: begin
            red_in = s6_byte_c_ff; green_in = s6_byte_0_ff; blue_in = byte_x;
         end
      endcase
   end

   // output register, holds the transaction while rsp_stream stalls
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= s6_alpha_ff;
      end
   end

   assign rsp_stream.valid   = vld_ff[NUM_STAGES];
   assign rsp_stream.payload = '{red: red_ff, green: green_ff, blue: blue_ff,
                                 alpha_out: alpha_ff};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_stream.valid && req_stream.ready |=> vld_ff[1])
      else $error("accepted transaction did not enter stage 1");

   a_hue_reduced: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> s2_hue_ff < FULL)
      else $error("hue not reduced below a full turn");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> s3_dist_ff <= SECTOR || !vld_ff[3])
      else $error("sector distance out of range");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] |-> s6_y_ff <= QMAX)
      else $error("secondary channel quotient out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && !adv[5] |=> vld_ff[4] && $stable(s4_e_ff))
      else $error("stalled stage 4 lost its content");

endmodule

`default_nettype wire
